// ===== sv/qcp_pkg.sv =====
// shared types and constants for the quadrature counter with pwm
`timescale 1ns / 1ps
`default_nettype none
package qcp_pkg;

   localparam logic [31:0] MAGIC_CLEAR  = 32'd59595959;
   localparam logic [31:0] DUTY_RESET   = 32'd500000;
   localparam logic [31:0] PERIOD_RESET = 32'd1000000;

   localparam logic ACTION_TICK  = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   typedef struct packed {
      logic               action;
      logic               pin_a_level;
      logic               pin_b_level;
      logic signed [31:0] write_data;
   } item_type;

endpackage
`default_nettype wire

// ===== sv/qcp_in_stage.sv =====
// input register stage holding one accepted item
`timescale 1ns / 1ps
`default_nettype none
module qcp_in_stage (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_action,
   input  wire logic               req_pin_a_level,
   input  wire logic               req_pin_b_level,
   input  wire logic signed [31:0] req_write_data,
   input  wire logic               item_go,
   output logic                    item_valid,
   output qcp_pkg::item_type       item
);

   logic              valid_ff;
   logic              valid_in;
   qcp_pkg::item_type item_ff;
   logic              accept;

   assign req_stall  = valid_ff && !item_go;
   assign accept     = req_valid && !req_stall;
   assign valid_in   = accept || (valid_ff && !item_go);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff.action      <= req_action;
         item_ff.pin_a_level <= req_pin_a_level;
         item_ff.pin_b_level <= req_pin_b_level;
         item_ff.write_data  <= req_write_data;
      end
   end

endmodule
`default_nettype wire

// ===== sv/qcp_core.sv =====
// encoder and pwm state, per-item update and result register
`timescale 1ns / 1ps
`default_nettype none
module qcp_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   input  wire qcp_pkg::item_type  item,
   output logic                    item_go,
   input  wire logic [31:0]        period,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_pwm_level,
   output logic signed [31:0]      rsp_position
);

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic               level_ff;
   logic               level_in;
   logic signed [31:0] position_ff;
   logic signed [31:0] position_in;
   logic signed [31:0] duty_ff;
   logic signed [31:0] duty_in;
   logic [31:0]        phase_ff;
   logic [31:0]        phase_in;
   logic               last_a_ff;
   logic               last_a_in;
   logic               last_b_ff;
   logic               last_b_in;
   logic [32:0]        phase_next;
   logic signed [31:0] pos_step;

   assign item_go       = item_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in  = item_go || (rsp_valid_ff && rsp_stall);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pwm_level = level_ff;
   assign rsp_position  = position_ff;
   assign phase_next    = {1'b0, phase_ff} + 33'd1;

   always_comb begin
      position_in = position_ff;
      duty_in     = duty_ff;
      phase_in    = phase_ff;
      last_a_in   = last_a_ff;
      last_b_in   = last_b_ff;
      pos_step    = '0;
      level_in    = level_ff;
      if (item.action == qcp_pkg::ACTION_TICK) begin
         // a change on both pins nets zero
         if (item.pin_a_level != last_a_ff) begin
            pos_step = (item.pin_a_level == item.pin_b_level) ? -32'sd1 : 32'sd1;
         end
         if (item.pin_b_level != last_b_ff) begin
            pos_step = pos_step +
               ((item.pin_b_level == item.pin_a_level) ? 32'sd1 : -32'sd1);
         end
         position_in = position_ff + pos_step;
         last_a_in   = item.pin_a_level;
         last_b_in   = item.pin_b_level;
         level_in    = !duty_ff[31] && (phase_ff < $unsigned(duty_ff));
         // zero period behaves like a period of one
         if (phase_next >= {1'b0, period}) begin
            phase_in = '0;
         end else begin
            phase_in = phase_next[31:0];
         end
      end else begin
         if ($unsigned(item.write_data) == qcp_pkg::MAGIC_CLEAR) begin
            position_in = '0;
         end else begin
            duty_in = item.write_data;
         end
         level_in = !duty_in[31] && (phase_ff < $unsigned(duty_in));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         position_ff  <= '0;
         duty_ff      <= $signed(qcp_pkg::DUTY_RESET);
         phase_ff     <= '0;
         last_a_ff    <= 1'b0;
         last_b_ff    <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (item_go) begin
            position_ff <= position_in;
            duty_ff     <= duty_in;
            phase_ff    <= phase_in;
            last_a_ff   <= last_a_in;
            last_b_ff   <= last_b_in;
         end
      end
      if (item_go) begin
         level_ff <= level_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/quadrature_counter_with_pwm.sv =====
// top level: quadrature position counter with pwm output
// results pass the input register, then the result register; rsp_stall can hold them
// throughput: one item per cycle while rsp_stall is low; the update is combinational
// req_stall rises only when the result register is full and held by rsp_stall
// reset (synchronous, active high): position 0, duty 500000, phase 0, pins 0,
// period 1000000, both stages empty
`timescale 1ns / 1ps
`default_nettype none
module quadrature_counter_with_pwm (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_action,
   input  wire logic               req_pin_a_level,
   input  wire logic               req_pin_b_level,
   input  wire logic signed [31:0] req_write_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_pwm_level,
   output logic signed [31:0]      rsp_position,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [31:0]        csr_pwm_period_ticks
);

   logic              item_valid;
   logic              item_go;
   qcp_pkg::item_type item;
   logic [31:0]       period_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= qcp_pkg::PERIOD_RESET;
      end else if (csr_valid && csr_ready) begin
         period_ff <= csr_pwm_period_ticks;
      end
   end

   qcp_in_stage u_in_stage (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_pin_a_level (req_pin_a_level),
      .req_pin_b_level (req_pin_b_level),
      .req_write_data  (req_write_data),
      .item_go         (item_go),
      .item_valid      (item_valid),
      .item            (item)
   );

   qcp_core u_core (
      .clock         (clock),
      .reset         (reset),
      .item_valid    (item_valid),
      .item          (item),
      .item_go       (item_go),
      .period        (period_ff),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pwm_level (rsp_pwm_level),
      .rsp_position  (rsp_position)
   );

endmodule
`default_nettype wire
